// ----- design/gpio_plk_pkg.sv -----
// gpio_plk_pkg: shared types, register map and pin mask helpers for the gpio port
// used by gpio_plk_lock, gpio_plk_regs and gpio_port_with_lock_sequence_unit
package gpio_plk_pkg;

  localparam int PinCountDef = 16;
  localparam int PinMax      = 16;
  localparam int IdxW        = 4;
  localparam int WordW       = 32;

  // register map
  localparam logic [IdxW-1:0] RegMode   = 4'd0;
  localparam logic [IdxW-1:0] RegOtype  = 4'd1;
  localparam logic [IdxW-1:0] RegSpeed  = 4'd2;
  localparam logic [IdxW-1:0] RegPull   = 4'd3;
  localparam logic [IdxW-1:0] RegInput  = 4'd4;
  localparam logic [IdxW-1:0] RegOutput = 4'd5;
  localparam logic [IdxW-1:0] RegSetRst = 4'd6;
  localparam logic [IdxW-1:0] RegLock   = 4'd7;
  localparam logic [IdxW-1:0] RegAltLo  = 4'd8;
  localparam logic [IdxW-1:0] RegAltHi  = 4'd9;
  localparam logic [IdxW-1:0] RegClear  = 4'd10;

  localparam int KeyBit = 16;

  // one bus access as held in the input register
  typedef struct packed {
    logic             is_write;
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] data;
    logic [PinMax-1:0] levels;
  } access_t;

  // lock status handed from the lock sequencer to the register file
  typedef struct packed {
    logic              engaged_nxt;
    logic [PinMax-1:0] pins_nxt;
    logic [PinMax-1:0] frozen;
  } lock_stat_t;

  function automatic logic [PinMax-1:0] pin_mask(input int n);
    logic [PinMax-1:0] m;
    for (int i = 0; i < PinMax; i++) begin
      m[i] = (i < n);
    end
    return m;
  endfunction

  // one bit per pin widened to a two-bit field per pin
  function automatic logic [WordW-1:0] widen2(input logic [PinMax-1:0] p);
    logic [WordW-1:0] r;
    for (int i = 0; i < PinMax; i++) begin
      r[2*i +: 2] = {2{p[i]}};
    end
    return r;
  endfunction

  // eight pins widened to a four-bit field per pin
  function automatic logic [WordW-1:0] widen4(input logic [7:0] p);
    logic [WordW-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{p[i]}};
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] guarded(input logic [WordW-1:0] old,
                                               input logic [WordW-1:0] data,
                                               input logic [WordW-1:0] frozen,
                                               input logic [WordW-1:0] valid);
    return ((old & frozen) | (data & ~frozen)) & valid;
  endfunction

endpackage

// ----- design/gpio_plk_lock.sv -----
// gpio_plk_lock: lock key sequencer and locked pin set
// depends on gpio_plk_pkg
module gpio_plk_lock
  import gpio_plk_pkg::*;
#(
  parameter int PIN_COUNT = PinCountDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  access_t    acc,
  output lock_stat_t stat
);

  localparam logic [PinMax-1:0] PinMask = pin_mask(PIN_COUNT);

  localparam logic [1:0] KeyIdle   = 2'd0;
  localparam logic [1:0] KeyFirst  = 2'd1;
  localparam logic [1:0] KeySecond = 2'd2;
  localparam logic [1:0] KeyThird  = 2'd3;

  logic [1:0]        stage_r, stage_nxt;
  logic [PinMax-1:0] key_pins_r, key_pins_nxt;
  logic [PinMax-1:0] locked_r, locked_nxt;
  logic              engaged_r, engaged_nxt;
  logic [PinMax-1:0] pins;
  logic              key;
  logic              same;

  assign pins = acc.data[PinMax-1:0] & PinMask;
  assign key  = acc.data[KeyBit];
  assign same = (pins == key_pins_r);

  always_comb begin
    stage_nxt    = stage_r;
    key_pins_nxt = key_pins_r;
    locked_nxt   = locked_r;
    engaged_nxt  = engaged_r;
    if (fire && acc.idx == RegLock) begin
      if (engaged_r) begin
        stage_nxt = KeyIdle;
      end else if (!acc.is_write) begin
        if (stage_r == KeyThird) begin
          engaged_nxt = 1'b1;
          locked_nxt  = key_pins_r;
        end
        stage_nxt = KeyIdle;
      end else begin
        unique case (stage_r)
          KeyIdle: begin
            if (key) begin
              stage_nxt    = KeyFirst;
              key_pins_nxt = pins;
            end
          end
          KeyFirst:  stage_nxt = (!key && same) ? KeySecond : KeyIdle;
          KeySecond: stage_nxt = (key && same) ? KeyThird : KeyIdle;
          default:   stage_nxt = KeyIdle;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= KeyIdle;
      key_pins_r <= '0;
      locked_r   <= '0;
      engaged_r  <= 1'b0;
    end else begin
      stage_r    <= stage_nxt;
      key_pins_r <= key_pins_nxt;
      locked_r   <= locked_nxt;
      engaged_r  <= engaged_nxt;
    end
  end

  assign stat.engaged_nxt = engaged_nxt;
  assign stat.pins_nxt    = locked_nxt;
  assign stat.frozen      = engaged_r ? locked_r : '0;

endmodule

// ----- design/gpio_plk_regs.sv -----
// gpio_plk_regs: configuration registers, output latch and read-back mux
// depends on gpio_plk_pkg and the lock status from gpio_plk_lock
module gpio_plk_regs
  import gpio_plk_pkg::*;
#(
  parameter int PIN_COUNT = PinCountDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  access_t           acc,
  input  lock_stat_t        stat,
  output logic [WordW-1:0]  read_data,
  output logic [PinMax-1:0] pin_drive
);

  localparam logic [PinMax-1:0] PinMask = pin_mask(PIN_COUNT);
  localparam logic [WordW-1:0]  Valid2  = widen2(PinMask);
  localparam logic [WordW-1:0]  ValidLo = widen4(PinMask[7:0]);
  localparam logic [WordW-1:0]  ValidHi = widen4(PinMask[15:8]);

  logic [WordW-1:0]  mode_r, mode_nxt;
  logic [PinMax-1:0] otype_r, otype_nxt;
  logic [WordW-1:0]  speed_r, speed_nxt;
  logic [WordW-1:0]  pull_r, pull_nxt;
  logic [PinMax-1:0] odr_r, odr_nxt;
  logic [WordW-1:0]  altlo_r, altlo_nxt;
  logic [WordW-1:0]  althi_r, althi_nxt;
  logic [WordW-1:0]  f2, flo, fhi;
  logic [PinMax-1:0] dlo;

  assign f2  = widen2(stat.frozen);
  assign flo = widen4(stat.frozen[7:0]);
  assign fhi = widen4(stat.frozen[15:8]);
  assign dlo = acc.data[PinMax-1:0];

  always_comb begin
    mode_nxt  = mode_r;
    otype_nxt = otype_r;
    speed_nxt = speed_r;
    pull_nxt  = pull_r;
    odr_nxt   = odr_r;
    altlo_nxt = altlo_r;
    althi_nxt = althi_r;
    if (fire && acc.is_write) begin
      unique case (acc.idx)
        RegMode:   mode_nxt  = guarded(mode_r, acc.data, f2, Valid2);
        RegOtype:  otype_nxt = (otype_r & stat.frozen) | (dlo & ~stat.frozen & PinMask);
        RegSpeed:  speed_nxt = guarded(speed_r, acc.data, f2, Valid2);
        RegPull:   pull_nxt  = guarded(pull_r, acc.data, f2, Valid2);
        RegOutput: odr_nxt   = dlo & PinMask;
        // set wins over reset when both name a pin
        RegSetRst: odr_nxt   = ((odr_r & ~acc.data[31:16]) | dlo) & PinMask;
        RegAltLo:  altlo_nxt = guarded(altlo_r, acc.data, flo, ValidLo);
        RegAltHi:  althi_nxt = guarded(althi_r, acc.data, fhi, ValidHi);
        RegClear:  odr_nxt   = odr_r & ~dlo & PinMask;
        default:   ;
      endcase
    end
  end

  always_comb begin
    read_data = '0;
    if (!acc.is_write) begin
      unique case (acc.idx)
        RegMode:   read_data = mode_r;
        RegOtype:  read_data = {16'd0, otype_r};
        RegSpeed:  read_data = speed_r;
        RegPull:   read_data = pull_r;
        RegInput:  read_data = {16'd0, acc.levels & PinMask};
        RegOutput: read_data = {16'd0, odr_r};
        RegLock:   read_data = {15'd0, stat.engaged_nxt, stat.pins_nxt};
        RegAltLo:  read_data = altlo_r;
        RegAltHi:  read_data = althi_r;
        default:   read_data = '0;
      endcase
    end
  end

  assign pin_drive = odr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      otype_r <= '0;
      speed_r <= '0;
      pull_r  <= '0;
      odr_r   <= '0;
      altlo_r <= '0;
      althi_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      otype_r <= otype_nxt;
      speed_r <= speed_nxt;
      pull_r  <= pull_nxt;
      odr_r   <= odr_nxt;
      altlo_r <= altlo_nxt;
      althi_r <= althi_nxt;
    end
  end

endmodule

// ----- design/gpio_port_with_lock_sequence_unit.sv -----
// gpio_port_with_lock_sequence_unit: top level of the 16-pin gpio port with lock key
// depends on gpio_plk_pkg, gpio_plk_lock and gpio_plk_regs
//
// usage
//   in_*  : one bus access per transfer; tuser is the access kind (0 read, 1 write),
//           tdata carries register index, write data and the sampled pin levels
//   out_* : exactly one result transfer per access, in order: read data (zero on
//           writes), the output latch now driven to the pins, and the lock flag
//   path: an accepted access lands in the input register, is decoded and applied
//           to the registers once the result register can take it, and its result is
//           shown from the result register, which drives out_tvalid and out_tdata
//   throughput: one access per cycle while out_tready stays high; the register update is a
//           single pass of short logic between the input and the result register
//   stall: while a result waits in the result register the input register can
//           still take one access; once both are full in_tready drops, and no
//           register state changes until the waiting result is transferred
//   reset: rst_n low clears all configuration registers, the output latch, the
//           lock and the key sequence, and empties both pipeline registers
//   lock: write the lock register with key 1, then 0, then 1 and the same pins,
//           then read it; configuration bits of those pins are frozen until reset
module gpio_port_with_lock_sequence_unit
  import gpio_plk_pkg::*;
#(
  parameter int PIN_COUNT = PinCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // reg_index[3:0], write_data[35:4], pin_levels[51:36], zero
  input  logic        in_tuser,   // func: 0 read, 1 write
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // read_data[31:0], pin_drive[47:32], lock_active[48], zero
);

  logic              in_valid_r;
  access_t           acc_r;
  logic              out_valid_r;
  logic [55:0]       out_data_r;
  logic              adv;    // result register can take a new value
  logic              fire;   // held access is applied this cycle
  lock_stat_t        stat;
  logic [WordW-1:0]  read_data;
  logic [PinMax-1:0] pin_drive;

  assign adv       = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      acc_r.is_write <= in_tuser;
      acc_r.idx      <= in_tdata[3:0];
      acc_r.data     <= in_tdata[35:4];
      acc_r.levels   <= in_tdata[51:36];
    end
  end

  gpio_plk_lock #(
    .PIN_COUNT(PIN_COUNT)
  ) u_lock (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .acc  (acc_r),
    .stat (stat)
  );

  gpio_plk_regs #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .acc      (acc_r),
    .stat     (stat),
    .read_data(read_data),
    .pin_drive(pin_drive)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {7'd0, stat.engaged_nxt, pin_drive, read_data};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/gpio_plk_checker.sv -----
// gpio_plk_checker: watches the access and result channels of the gpio port, predicts
// every result from its own register and lock key model and compares field by field
// depends on gpio_plk_pkg for the register map and widths
module gpio_plk_checker
  import gpio_plk_pkg::*;
#(
  parameter int PIN_COUNT = PinCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,   // reg_index[3:0], write_data[35:4], pin_levels[51:36], zero
  input  logic        in_tuser,   // func: 0 read, 1 write
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // read_data[31:0], pin_drive[47:32], lock_active[48], zero
  output int          mismatches,
  output int          awaited,
  output int          matched,
  output logic        lock_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [PinMax-1:0] PinsUsed =
    (PIN_COUNT >= PinMax) ? '1 : PinMax'((1 << PIN_COUNT) - 1);

  typedef struct packed {
    logic [WordW-1:0]  rd;
    logic [PinMax-1:0] drive;
    logic              locked;
  } port_view_t;

  typedef enum logic [1:0] {KeyIdle, KeyFirst, KeySecond, KeyThird} key_step_t;

  logic [WordW-1:0]  mode_q, speed_q, pull_q, altlo_q, althi_q;
  logic [PinMax-1:0] otype_q, latch_q, frozen_q, key_pins_q;
  logic              engaged_q;
  key_step_t         step_q;
  port_view_t        view_q[$];

  initial begin
    mismatches = 0;
    awaited    = 0;
    matched    = 0;
    lock_seen  = 1'b0;
  end

  // per pin flag copied over a field of fw bits, pins base .. base+n-1
  function automatic logic [WordW-1:0] spread(input logic [PinMax-1:0] pins, input int base,
                                              input int n, input int fw);
    logic [WordW-1:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      if (pins[base+i]) r |= ((WordW'(1) << fw) - 1) << (i * fw);
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] merge_cfg(input logic [WordW-1:0] cur,
                                                 input logic [WordW-1:0] wd,
                                                 input logic [WordW-1:0] hold,
                                                 input logic [WordW-1:0] used);
    return (cur & hold) | (wd & ~hold & used);
  endfunction

  // key sequence: 1, 0, 1 with the same pins, then a read engages the lock
  function automatic void key_access(input logic wr, input logic [WordW-1:0] wd);
    logic [PinMax-1:0] pins;
    logic              key;
    pins = wd[PinMax-1:0] & PinsUsed;
    key  = wd[KeyBit];
    if (engaged_q) begin
      step_q = KeyIdle;
    end else if (!wr) begin
      if (step_q == KeyThird) begin
        engaged_q = 1'b1;
        frozen_q  = key_pins_q;
      end
      step_q = KeyIdle;
    end else begin
      case (step_q)
        KeyIdle: begin
          if (key) begin
            step_q     = KeyFirst;
            key_pins_q = pins;
          end
        end
        KeyFirst: begin
          if (!key && pins == key_pins_q) step_q = KeySecond;
          else step_q = KeyIdle;
        end
        KeySecond: begin
          if (key && pins == key_pins_q) step_q = KeyThird;
          else step_q = KeyIdle;
        end
        default: step_q = KeyIdle;
      endcase
    end
  endfunction

  function automatic port_view_t apply_access(input logic wr, input logic [IdxW-1:0] idx,
                                              input logic [WordW-1:0] wd,
                                              input logic [PinMax-1:0] lv);
    logic [PinMax-1:0] hold;
    logic [WordW-1:0]  h2, u2, hlo, hhi, ulo, uhi;
    port_view_t        r;
    hold = engaged_q ? frozen_q : '0;
    h2   = spread(hold, 0, 16, 2);
    u2   = spread(PinsUsed, 0, 16, 2);
    hlo  = spread(hold, 0, 8, 4);
    hhi  = spread(hold, 8, 8, 4);
    ulo  = spread(PinsUsed, 0, 8, 4);
    uhi  = spread(PinsUsed, 8, 8, 4);
    r.rd = '0;
    if (wr) begin
      case (idx)
        RegMode:   mode_q  = merge_cfg(mode_q, wd, h2, u2);
        RegOtype:  otype_q = (otype_q & hold) | (wd[PinMax-1:0] & ~hold & PinsUsed);
        RegSpeed:  speed_q = merge_cfg(speed_q, wd, h2, u2);
        RegPull:   pull_q  = merge_cfg(pull_q, wd, h2, u2);
        RegOutput: latch_q = wd[PinMax-1:0] & PinsUsed;
        RegSetRst: latch_q = ((latch_q & ~wd[31:16]) | wd[15:0]) & PinsUsed;
        RegLock:   key_access(1'b1, wd);
        RegAltLo:  altlo_q = merge_cfg(altlo_q, wd, hlo, ulo);
        RegAltHi:  althi_q = merge_cfg(althi_q, wd, hhi, uhi);
        RegClear:  latch_q = latch_q & ~wd[15:0] & PinsUsed;
        default: ;
      endcase
    end else begin
      case (idx)
        RegMode:   r.rd = mode_q;
        RegOtype:  r.rd = {16'd0, otype_q};
        RegSpeed:  r.rd = speed_q;
        RegPull:   r.rd = pull_q;
        RegInput:  r.rd = {16'd0, lv & PinsUsed};
        RegOutput: r.rd = {16'd0, latch_q};
        RegLock: begin
          key_access(1'b0, wd);
          r.rd = {15'd0, engaged_q, frozen_q};
        end
        RegAltLo:  r.rd = altlo_q;
        RegAltHi:  r.rd = althi_q;
        default:   r.rd = '0;
      endcase
    end
    r.drive  = latch_q;
    r.locked = engaged_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    port_view_t want;
    port_view_t got;
    if (!rst_n) begin
      mode_q     = '0;
      speed_q    = '0;
      pull_q     = '0;
      altlo_q    = '0;
      althi_q    = '0;
      otype_q    = '0;
      latch_q    = '0;
      frozen_q   = '0;
      key_pins_q = '0;
      engaged_q  = 1'b0;
      step_q     = KeyIdle;
      view_q.delete();
    end else begin
      // results leave before new accesses enter: a result never belongs to
      // an access taken at the same edge
      if (out_tvalid && out_tready) begin
        got.rd     = out_tdata[31:0];
        got.drive  = out_tdata[47:32];
        got.locked = out_tdata[48];
        if (view_q.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_tdata);
          mismatches++;
        end else begin
          want = view_q.pop_front();
          if (got.rd !== want.rd) begin
            $error("read_data: expected %h, actual %h", want.rd, got.rd);
            mismatches++;
          end
          if (got.drive !== want.drive) begin
            $error("pin_drive: expected %h, actual %h", want.drive, got.drive);
            mismatches++;
          end
          if (got.locked !== want.locked) begin
            $error("lock_active: expected %b, actual %b", want.locked, got.locked);
            mismatches++;
          end
          matched++;
        end
      end
      if (in_tvalid && in_tready) begin
        view_q.push_back(apply_access(in_tuser, in_tdata[3:0], in_tdata[35:4],
                                      in_tdata[51:36]));
      end
    end
    awaited   = view_q.size();
    lock_seen = engaged_q;
  end

endmodule

// ----- tb/tb_gpio_port_with_lock_sequence_unit.sv -----
// tb_gpio_port_with_lock_sequence_unit: stimulus and verdict for the gpio port with lock key
// depends on gpio_plk_pkg, the gpio port RTL and gpio_plk_checker
module tb_gpio_port_with_lock_sequence_unit
  import gpio_plk_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // reg_index[3:0], write_data[35:4], pin_levels[51:36], zero
  logic        in_tuser;   // func: 0 read, 1 write
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // read_data[31:0], pin_drive[47:32], lock_active[48], zero

  int   mismatches;
  int   awaited;
  int   matched;
  logic lock_seen;

  // random idle bursts on both sides while set; cleared for the closing stretch
  bit gaps_on = 1'b1;
  int sent;
  int reads_sent;
  int writes_sent;
  int key_runs;

  gpio_port_with_lock_sequence_unit #(
    .PIN_COUNT(PinCountDef)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  gpio_plk_checker #(
    .PIN_COUNT(PinCountDef)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .awaited   (awaited),
    .matched   (matched),
    .lock_seen (lock_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side back-pressure: random stall bursts while gaps_on is set
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // one access transfer; entered and left at a falling edge with valid still high,
  // so back-to-back calls never lower and raise valid in the same step
  task automatic put_access(input logic wr, input logic [3:0] idx,
                            input logic [31:0] wd, input logic [15:0] lv);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= wr;
    in_tdata  <= {4'd0, lv, wd, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (wr) writes_sent++;
    else reads_sent++;
  endtask

  // data word biased toward all zeros, all ones and half-word patterns
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {16'($urandom()), 16'd0};
      3: return {16'd0, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  // any register, any kind; inside a key sequence the lock register is kept out
  task automatic put_random(input bit with_lock);
    logic [3:0] idx;
    idx = 4'($urandom_range(0, 15));
    if (!with_lock && idx == RegLock) idx = RegSetRst;
    put_access(1'($urandom_range(0, 1)), idx, rand_word(), 16'($urandom()));
  endtask

  // unrelated register traffic between key steps, which must not disturb the sequence
  task automatic stir();
    repeat ($urandom_range(0, 2)) put_random(1'b0);
  endtask

  // lock register write; bits 31..17 carry junk the block has to ignore
  task automatic lock_write(input logic key, input logic [15:0] pins);
    put_access(1'b1, RegLock, {15'($urandom()), key, pins}, 16'($urandom()));
  endtask

  // break the sequence: read too early, wrong key value, or one pin changed
  task automatic spoil(input logic [15:0] pins, input logic key_due);
    case ($urandom_range(0, 2))
      0: put_access(1'b0, RegLock, $urandom(), 16'($urandom()));
      1: lock_write(!key_due, pins);
      default: lock_write(key_due, pins ^ (16'd1 << $urandom_range(0, 15)));
    endcase
  endtask

  // key sequence 1, 0, 1 then read; unless finish is set it is cut at a random step
  task automatic key_run(input bit finish);
    logic [15:0] pins;
    int          cut;
    case ($urandom_range(0, 3))
      0: pins = '0;
      1: pins = '1;
      default: pins = 16'($urandom());
    endcase
    cut = finish ? 3 : $urandom_range(0, 2);
    key_runs++;
    lock_write(1'b1, pins);
    stir();
    if (cut == 0) begin
      spoil(pins, 1'b0);
      return;
    end
    lock_write(1'b0, pins);
    stir();
    if (cut == 1) begin
      spoil(pins, 1'b1);
      return;
    end
    lock_write(1'b1, pins);
    stir();
    if (cut == 2) begin
      // a write where the closing read is due
      lock_write(1'($urandom_range(0, 1)), 16'($urandom()));
      return;
    end
    put_access(1'b0, RegLock, $urandom(), 16'($urandom()));
  endtask

  // stop sending and let every outstanding result drain, plus pipeline slack
  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    in_tdata  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes of every register, set/reset priority, write-only and
    // unused indexes, and key sequences that must not lock
    put_access(1'b1, RegMode,   '1, '0);
    put_access(1'b0, RegMode,   '0, '0);
    put_access(1'b1, RegOtype,  '1, '0);
    put_access(1'b0, RegOtype,  '0, '0);
    put_access(1'b1, RegSpeed,  32'hA5A5_5A5A, '0);
    put_access(1'b1, RegPull,   32'h5A5A_A5A5, '1);
    put_access(1'b1, RegAltLo,  '1, '0);
    put_access(1'b1, RegAltHi,  32'h8421_0F0F, '0);
    put_access(1'b0, RegAltHi,  '0, '0);
    put_access(1'b1, RegInput,  '1, '1);     // input register ignores writes
    put_access(1'b0, RegInput,  '0, '1);
    put_access(1'b0, RegInput,  '1, '0);
    put_access(1'b1, RegOutput, 32'hFFFF_0000, '0);
    put_access(1'b1, RegSetRst, '1, '0);     // set and reset on every pin: set wins
    put_access(1'b1, RegSetRst, 32'h00FF_0F00, '0);
    put_access(1'b1, RegClear,  32'hFFFF_000F, '0);
    put_access(1'b0, RegSetRst, '1, '0);     // write-only registers read zero
    put_access(1'b0, RegClear,  '1, '0);
    put_access(1'b1, 4'd15,     '1, '1);     // unused index
    put_access(1'b0, 4'd11,     '1, '1);
    put_access(1'b0, RegOutput, '0, '0);
    lock_write(1'b1, 16'h00F3);
    put_access(1'b0, RegLock, '0, '0);       // read before the sequence is complete
    lock_write(1'b0, 16'h00F3);              // key 0 with nothing begun
    lock_write(1'b1, 16'h00F3);
    lock_write(1'b1, 16'h00F3);              // deviation, must not restart the sequence
    put_access(1'b0, RegLock, '0, '0);

    // unlocked random traffic with cut-short key sequences
    while (sent < 700) begin
      if ($urandom_range(0, 9) < 3) key_run(1'b0);
      else put_random(1'b1);
    end

    // hold off until the block is idle, then lock a random pin set
    drain();
    key_run(1'b1);

    // locked: frozen configuration, lock writes ignored, output latch still free
    while (sent < 1200) begin
      if (sent >= 1000) gaps_on = 1'b0;
      if ($urandom_range(0, 9) < 2) key_run(1'($urandom_range(0, 1)));
      else put_random(1'b1);
    end

    drain();
    $display("covered %0d accesses (%0d reads, %0d writes), %0d key sequences",
             sent, reads_sent, writes_sent, key_runs);
    $display("%0d results checked, lock engaged: %s", matched, lock_seen ? "yes" : "no");
    if (mismatches == 0 && awaited == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/gpio_plk_pkg.sv
design/gpio_plk_lock.sv
design/gpio_plk_regs.sv
design/gpio_port_with_lock_sequence_unit.sv
tb/gpio_plk_checker.sv
tb/tb_gpio_port_with_lock_sequence_unit.sv
